>>> hdl/rdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS decibel meter package
// Shared constants, state types and width helpers for the level meter.
// ----------------------------------------------------------------------------
package rdm_pkg;

    localparam int WLEN_W = 17;
    localparam logic [WLEN_W-1:0] WINDOW_LEN_RESET = 17'd44100;

    localparam int LEVEL_W = 16;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 16'h8000;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'h7FFF;
    localparam int LEVEL_MAG_NEG = 32768;
    localparam int LEVEL_MAG_POS = 32767;

    localparam int FRAC_BITS = 16;
    localparam int MANT_W = 31;
    localparam int MANT_Q = 30;

    localparam int SCALE_W = 26;
    localparam logic [SCALE_W-1:0] DB_SCALE_Q16 = 26'd50504453;
    localparam int RND_SH = 32;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        LOG_IDLE,
        LOG_NORM,
        LOG_ITER
    } t_log_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOG,
        BK_DIFF,
        BK_MUL,
        BK_WRITE
    } t_back_state;

    function automatic int log_pw(input int xw);
        int r;
        if (xw <= 32) begin
            r = 32;
        end else begin
            r = 1 << $clog2(xw);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/windowed_rms_decibel_meter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed RMS decibel meter
// Takes one sample per cycle while the job queue has room. A window's level
// is computed after its last sample, mostly in the log2 squaring steps.
// The back end takes a new window only when done with the last one, so
// short windows throttle the sample input through the two-entry job queue.
// Synchronous reset clears the accumulator, the count, the queue and the
// result valid flag, and sets the window length to 44100 samples.
// ----------------------------------------------------------------------------
module windowed_rms_decibel_meter #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int MAX_WINDOW_LOG2 = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rdm_pkg::WLEN_W-1:0]        i_cfg_window_len,
    input  wire logic                              i_sample_valid,
    output logic                                   o_sample_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    i_sample,
    output logic                                   o_level_valid,
    input  wire logic                              i_level_ready,
    output logic signed [rdm_pkg::LEVEL_W-1:0]     o_level_db,
    output logic                                   o_silent
);
    import rdm_pkg::*;

    localparam int EW = 2 * SAMPLE_WIDTH - 1 + MAX_WINDOW_LOG2;
    localparam int NW = MAX_WINDOW_LOG2 + 1;
    localparam int JW = EW + NW;

    logic          front_valid;
    logic          front_ready;
    logic [EW-1:0] front_energy;
    logic [NW-1:0] front_len;
    logic          back_valid;
    logic          back_ready;
    logic [JW-1:0] back_data;

    rdm_front #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_window_len (i_cfg_window_len),
        .i_sample_valid   (i_sample_valid),
        .o_sample_ready   (o_sample_ready),
        .i_sample         (i_sample),
        .o_job_valid      (front_valid),
        .i_job_ready      (front_ready),
        .o_job_energy     (front_energy),
        .o_job_len        (front_len)
    );

    rdm_queue #(.DATA_W(JW)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (front_valid),
        .o_in_ready  (front_ready),
        .i_in_data   ({front_energy, front_len}),
        .o_out_valid (back_valid),
        .i_out_ready (back_ready),
        .o_out_data  (back_data)
    );

    rdm_back #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (back_valid),
        .o_job_ready   (back_ready),
        .i_job_energy  (back_data[JW-1:NW]),
        .i_job_len     (back_data[NW-1:0]),
        .o_level_valid (o_level_valid),
        .i_level_ready (i_level_ready),
        .o_level_db    (o_level_db),
        .o_silent      (o_silent)
    );

endmodule
`default_nettype wire

>>> hdl/rdm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS decibel meter front end
// Holds the window length, squares each sample and accumulates the window
// energy; a finished window is pushed towards the back end as one job.
// ----------------------------------------------------------------------------
module rdm_front #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int MAX_WINDOW_LOG2 = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  wire logic [rdm_pkg::WLEN_W-1:0]               i_cfg_window_len,
    input  wire logic                                     i_sample_valid,
    output logic                                          o_sample_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]           i_sample,
    output logic                                          o_job_valid,
    input  wire logic                                     i_job_ready,
    output logic [2*SAMPLE_WIDTH-2+MAX_WINDOW_LOG2:0]     o_job_energy,
    output logic [MAX_WINDOW_LOG2:0]                      o_job_len
);
    import rdm_pkg::*;

    localparam int EW   = 2 * SAMPLE_WIDTH - 1 + MAX_WINDOW_LOG2;
    localparam int NW   = MAX_WINDOW_LOG2 + 1;
    localparam int SQW  = 2 * SAMPLE_WIDTH - 1;
    localparam int CMPW = (WLEN_W > NW) ? WLEN_W : NW;
    localparam logic [CMPW-1:0] LEN_LIMIT = CMPW'(1) << MAX_WINDOW_LOG2;

    logic [WLEN_W-1:0]         r_window_len;
    logic                      r_sq_valid;
    logic [SQW-1:0]            r_sq;
    logic [EW-1:0]             r_energy;
    logic [NW-1:0]             r_count;

    logic [CMPW-1:0]           wl_ext;
    logic [CMPW-1:0]           eff_wide;
    logic [NW-1:0]             eff_len;
    logic [SAMPLE_WIDTH-1:0]   raw;
    logic [SAMPLE_WIDTH-1:0]   mag;
    logic [2*SAMPLE_WIDTH-1:0] sq_full;
    logic [NW-1:0]             count_inc;
    logic [EW-1:0]             energy_sum;
    logic                      last;
    logic                      advance;
    logic                      accept;

    assign wl_ext = CMPW'(r_window_len);

    always_comb begin
        if (wl_ext == '0) begin
            eff_wide = CMPW'(1);
        end else if (wl_ext > LEN_LIMIT) begin
            eff_wide = LEN_LIMIT;
        end else begin
            eff_wide = wl_ext;
        end
    end

    assign eff_len = eff_wide[NW-1:0];

    assign raw     = i_sample;
    assign mag     = raw[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(~raw + 1'b1) : raw;
    assign sq_full = mag * mag;

    assign count_inc  = r_count + NW'(1);
    assign energy_sum = r_energy + EW'(r_sq);
    assign last       = count_inc >= eff_len;
    assign advance    = r_sq_valid && (!last || i_job_ready);
    assign accept     = i_sample_valid && o_sample_ready;

    assign o_cfg_ready    = 1'b1;
    assign o_sample_ready = !r_sq_valid || advance;
    assign o_job_valid    = r_sq_valid && last;
    assign o_job_energy   = energy_sum;
    assign o_job_len      = eff_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_LEN_RESET;
            r_sq_valid   <= 1'b0;
            r_energy     <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_window_len <= i_cfg_window_len;
            end
            if (accept) begin
                r_sq_valid <= 1'b1;
            end else if (advance) begin
                r_sq_valid <= 1'b0;
            end
            if (advance) begin
                if (last) begin
                    r_energy <= '0;
                    r_count  <= '0;
                end else begin
                    r_energy <= energy_sum;
                    r_count  <= count_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sq <= sq_full[SQW-1:0];
        end
    end

endmodule
`default_nettype wire

>>> hdl/rdm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS decibel meter job queue
// Short first-in first-out buffer of finished windows between the front
// end and the back end.
// ----------------------------------------------------------------------------
module rdm_queue #(
    parameter int DATA_W = 65
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [DATA_W-1:0] i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [DATA_W-1:0]      o_out_data
);
    import rdm_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;

    logic push;
    logic pop;

    assign o_in_ready  = r_fill != FILL_W'(QUEUE_DEPTH);
    assign o_out_valid = r_fill != '0;
    assign o_out_data  = r_mem[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_in_data;
        end
    end

endmodule
`default_nettype wire

>>> hdl/rdm_log2.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS decibel meter base-two logarithm
// Sequential log2 with sixteen fraction bits: a binary normalisation, one
// halving step per cycle, then one mantissa squaring per fraction bit.
// ----------------------------------------------------------------------------
module rdm_log2 #(
    parameter int XW = 47
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [XW-1:0]  i_x,
    output logic                o_busy,
    output logic [$clog2(rdm_pkg::log_pw(XW))+rdm_pkg::FRAC_BITS-1:0] o_log
);
    import rdm_pkg::*;

    localparam int PW    = log_pw(XW);
    localparam int SHW   = $clog2(PW);
    localparam int FCW   = $clog2(FRAC_BITS);
    localparam int CNT_W = (SHW > FCW) ? SHW : FCW;
    localparam logic [SHW:0] PW_V = (SHW + 1)'(PW);

    t_log_state r_state;
    t_log_state n_state;

    logic [PW-1:0]        r_y;
    logic [SHW-1:0]       r_lz;
    logic [CNT_W-1:0]     r_cnt;
    logic [MANT_W-1:0]    r_m;
    logic [FRAC_BITS-1:0] r_frac;

    logic [SHW:0]         shift_amt;
    logic                 top_zero;
    logic [PW-1:0]        y_norm;
    logic [SHW-1:0]       lz_norm;
    logic [2*MANT_W-1:0]  m_sq;
    logic [MANT_W:0]      mm;
    logic                 norm_end;
    logic                 iter_end;

    assign shift_amt = PW_V >> (r_cnt + CNT_W'(1));
    assign top_zero  = (r_y >> (PW_V - shift_amt)) == '0;
    assign y_norm    = top_zero ? (r_y << shift_amt) : r_y;
    assign lz_norm   = top_zero ? (r_lz + SHW'(shift_amt)) : r_lz;
    assign m_sq      = r_m * r_m;
    assign mm        = m_sq[2*MANT_W-1:MANT_Q];
    assign norm_end  = r_cnt == CNT_W'(SHW - 1);
    assign iter_end  = r_cnt == CNT_W'(FRAC_BITS - 1);

    assign o_busy = r_state != LOG_IDLE;
    assign o_log  = {SHW'(PW - 1) - r_lz, r_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LOG_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            LOG_IDLE: begin
                if (i_start) begin
                    n_state = LOG_NORM;
                end
            end
            LOG_NORM: begin
                if (norm_end) begin
                    n_state = LOG_ITER;
                end
            end
            LOG_ITER: begin
                if (iter_end) begin
                    n_state = LOG_IDLE;
                end
            end
            default: begin
                n_state = LOG_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            LOG_IDLE: begin
                if (i_start) begin
                    r_y   <= PW'(i_x);
                    r_lz  <= '0;
                    r_cnt <= '0;
                end
            end
            LOG_NORM: begin
                r_y  <= y_norm;
                r_lz <= lz_norm;
                if (norm_end) begin
                    r_m   <= y_norm[PW-1 -: MANT_W];
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            LOG_ITER: begin
                r_frac <= {r_frac[FRAC_BITS-2:0], mm[MANT_W]};
                r_m    <= mm[MANT_W] ? mm[MANT_W:1] : mm[MANT_W-1:0];
                r_cnt  <= r_cnt + CNT_W'(1);
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/rdm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS decibel meter back end
// Turns one window job into a level: logarithms of energy and length, the
// difference scaled to 1/256 dB, rounding, saturation and a result register.
// ----------------------------------------------------------------------------
module rdm_back #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int MAX_WINDOW_LOG2 = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_job_valid,
    output logic                                        o_job_ready,
    input  wire logic [2*SAMPLE_WIDTH-2+MAX_WINDOW_LOG2:0] i_job_energy,
    input  wire logic [MAX_WINDOW_LOG2:0]               i_job_len,
    output logic                                        o_level_valid,
    input  wire logic                                   i_level_ready,
    output logic signed [rdm_pkg::LEVEL_W-1:0]          o_level_db,
    output logic                                        o_silent
);
    import rdm_pkg::*;

    localparam int EW  = 2 * SAMPLE_WIDTH - 1 + MAX_WINDOW_LOG2;
    localparam int NW  = MAX_WINDOW_LOG2 + 1;
    localparam int LEW = $clog2(log_pw(EW)) + FRAC_BITS;
    localparam int LNW = $clog2(log_pw(NW)) + FRAC_BITS;
    localparam int DW  = ((LEW > LNW) ? LEW : LNW) + 1;
    localparam int AW  = DW + SCALE_W;
    localparam int RW  = AW + 1 - RND_SH;
    localparam logic [AW:0] ROUND_HALF = (AW + 1)'(1) << (RND_SH - 1);

    t_back_state r_state;
    t_back_state n_state;

    logic                     r_job_silent;
    logic                     r_neg;
    logic [DW-1:0]            r_ad;
    logic [AW-1:0]            r_prod;
    logic                     r_out_valid;
    logic [LEVEL_W-1:0]       r_level;
    logic                     r_out_silent;

    logic                     start;
    logic                     busy_e;
    logic                     busy_n;
    logic [LEW-1:0]           log_e;
    logic [LNW-1:0]           log_n;
    logic signed [DW-1:0]     diff;
    logic [AW:0]              rounded;
    logic [RW-1:0]            mag_r;
    logic [LEVEL_W-1:0]       level;
    logic                     write_out;

    rdm_log2 #(.XW(EW)) u_log_energy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_x     (i_job_energy),
        .o_busy  (busy_e),
        .o_log   (log_e)
    );

    rdm_log2 #(.XW(NW)) u_log_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_x     (i_job_len),
        .o_busy  (busy_n),
        .o_log   (log_n)
    );

    assign diff    = $signed(DW'(log_e)) - $signed(DW'(log_n));
    assign rounded = (AW + 1)'(r_prod) + ROUND_HALF;
    assign mag_r   = rounded[AW:RND_SH];

    always_comb begin
        if (r_job_silent) begin
            level = LEVEL_MIN;
        end else if (r_neg) begin
            level = (mag_r > RW'(LEVEL_MAG_NEG)) ? LEVEL_MIN : LEVEL_W'(~mag_r + RW'(1));
        end else begin
            level = (mag_r > RW'(LEVEL_MAG_POS)) ? LEVEL_MAX : LEVEL_W'(mag_r);
        end
    end

    assign o_job_ready   = r_state == BK_IDLE;
    assign start         = (r_state == BK_IDLE) && i_job_valid;
    assign write_out     = (r_state == BK_WRITE) && (!r_out_valid || i_level_ready);
    assign o_level_valid = r_out_valid;
    assign o_level_db    = r_level;
    assign o_silent      = r_out_silent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    n_state = BK_LOG;
                end
            end
            BK_LOG: begin
                if (!busy_e && !busy_n) begin
                    n_state = BK_DIFF;
                end
            end
            BK_DIFF: begin
                n_state = BK_MUL;
            end
            BK_MUL: begin
                n_state = BK_WRITE;
            end
            BK_WRITE: begin
                if (write_out) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_job_silent <= i_job_energy == '0;
        end
        if (r_state == BK_DIFF) begin
            r_neg <= diff[DW-1];
            r_ad  <= diff[DW-1] ? DW'(-diff) : DW'(diff);
        end
        if (r_state == BK_MUL) begin
            r_prod <= AW'(r_ad) * AW'(DB_SCALE_Q16);
        end
        if (write_out) begin
            r_level      <= level;
            r_out_silent <= r_job_silent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (write_out) begin
            r_out_valid <= 1'b1;
        end else if (i_level_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire
